/* sv/swmf_pkg.sv */
// Shared types and fixed field widths for the sliding window median filter.
package swmf_pkg;

   // Widths of the request and response payload fields.
   localparam int SAMPLE_W = 16;
   localparam int MEDIAN_W = 16;

   // Control handed from one cell to the next along the chain.
   typedef struct packed {
      logic del_seen;  // the evicted entry sits at or above this cell
      logic ge;        // compacted entry here is valid and not below the new sample
   } link_type;

endpackage

/* sv/swmf_cell.sv */
// One cell of the sorted chain: holds a value and its slot, evicts and inserts in place.
module swmf_cell #(
   parameter int DATA_WIDTH = 16,
   parameter int SLOT_W     = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   full,
   input  logic [SLOT_W-1:0]      oldest_slot,
   input  logic [DATA_WIDTH-1:0]  new_value,
   input  logic [SLOT_W-1:0]      new_slot,
   input  swmf_pkg::link_type     prev_link,
   input  logic                   prev_vld,
   input  logic [DATA_WIDTH-1:0]  prev_val,
   input  logic [SLOT_W-1:0]      prev_slot,
   input  logic                   next_vld,
   input  logic [DATA_WIDTH-1:0]  next_val,
   input  logic [SLOT_W-1:0]      next_slot,
   output logic                   own_vld,
   output logic [DATA_WIDTH-1:0]  own_val,
   output logic [SLOT_W-1:0]      own_slot,
   output logic                   comp_vld,
   output logic [DATA_WIDTH-1:0]  comp_val,
   output logic [SLOT_W-1:0]      comp_slot,
   output swmf_pkg::link_type     link_out
);

   logic                  vld_ff, vld_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic                  own_del;
   logic                  del_seen;
   logic                  comp_ge;

   // Compact: once the evicted entry is at or above, pull the lower neighbour up.
   always_comb begin
      own_del  = vld_ff && full && (slot_ff == oldest_slot);
      del_seen = prev_link.del_seen || own_del;
      if (del_seen) begin
         comp_vld  = next_vld;
         comp_val  = next_val;
         comp_slot = next_slot;
      end else begin
         comp_vld  = vld_ff;
         comp_val  = val_ff;
         comp_slot = slot_ff;
      end
      comp_ge  = comp_vld && (comp_val >= new_value);
      link_out = '{del_seen: del_seen, ge: comp_ge};
   end

   // Insert: keep entries not below the new sample, drop the sample in at the boundary,
   // shift the rest down by one.
   always_comb begin
      if (comp_ge) begin
         vld_in  = comp_vld;
         val_in  = comp_val;
         slot_in = comp_slot;
      end else if (prev_link.ge) begin
         vld_in  = 1'b1;
         val_in  = new_value;
         slot_in = new_slot;
      end else begin
         vld_in  = prev_vld;
         val_in  = prev_val;
         slot_in = prev_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (enable) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         val_ff  <= val_in;
         slot_ff <= slot_in;
      end
   end

   assign own_vld  = vld_ff;
   assign own_val  = val_ff;
   assign own_slot = slot_ff;

endmodule

/* sv/sliding_window_median_filter.sv */
// Top level of the sliding window median filter: cell chain, fill tracking, response stage.
//
// Each request beat carries one unsigned sample; each response beat carries the lower
// median of the last WINDOW samples (fewer before the window has filled: with k samples,
// the (k/2+1)-th largest, counting from one).
// The samples sit in a chain of WINDOW cells kept sorted from largest to smallest. On an
// accepted beat every cell, in the same cycle, drops the oldest sample (once the window is
// full) and makes room for the new one by looking only at its two neighbours.
// Once the chain has updated, the median cell is read into the response register as soon
// as that register is empty or being emptied, and the result is offered from there.
// Throughput is one beat per cycle while the response side does not stall, set by the
// update of the whole cell chain on each accepted beat.
// A stall on the response side holds the response register; the chain then holds one
// finished update and raises req_stall until the response register can take it.
// Reset (synchronous, active high) empties the chain and clears the fill count, the
// oldest-slot pointer and both valid flags; no clearing pass is needed.
module sliding_window_median_filter #(
   parameter int WINDOW     = 15,
   parameter int DATA_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [swmf_pkg::SAMPLE_W-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [swmf_pkg::MEDIAN_W-1:0] rsp_median_value
);

   localparam int SLOT_W  = $clog2(WINDOW);
   localparam int COUNT_W = $clog2(WINDOW + 1);

   logic                  accept;
   logic                  capture;
   logic                  full;
   logic [DATA_WIDTH-1:0] sample_w;
   logic [SLOT_W-1:0]     pick;

   logic [SLOT_W-1:0]     oldest_ff, oldest_in;
   logic [COUNT_W-1:0]    fill_ff, fill_in;
   logic                  pend_ff, pend_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [swmf_pkg::MEDIAN_W-1:0] median_ff;

   swmf_pkg::link_type    link   [WINDOW+1];
   logic                  c_vld  [WINDOW+1];
   logic [DATA_WIDTH-1:0] c_val  [WINDOW+1];
   logic [SLOT_W-1:0]     c_slot [WINDOW+1];
   logic                  o_vld  [WINDOW+1];
   logic [DATA_WIDTH-1:0] o_val  [WINDOW+1];
   logic [SLOT_W-1:0]     o_slot [WINDOW+1];

   assign sample_w  = DATA_WIDTH'(req_sample);
   assign full      = (fill_ff == COUNT_W'(WINDOW));
   assign capture   = pend_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = pend_ff && !capture;
   assign accept    = req_valid && !req_stall;

   // Head of the chain: nothing above cell 0, so the sample goes there unless cell 0 keeps.
   assign link[0]   = '{del_seen: 1'b0, ge: 1'b1};
   assign c_vld[0]  = 1'b0;
   assign c_val[0]  = '0;
   assign c_slot[0] = '0;
   // Tail of the chain: an empty entry below the last cell.
   assign o_vld[WINDOW]  = 1'b0;
   assign o_val[WINDOW]  = '0;
   assign o_slot[WINDOW] = '0;

   for (genvar g = 0; g < WINDOW; g++) begin : g_cell
      swmf_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .SLOT_W     (SLOT_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .enable      (accept),
         .full        (full),
         .oldest_slot (oldest_ff),
         .new_value   (sample_w),
         .new_slot    (oldest_ff),
         .prev_link   (link[g]),
         .prev_vld    (c_vld[g]),
         .prev_val    (c_val[g]),
         .prev_slot   (c_slot[g]),
         .next_vld    (o_vld[g+1]),
         .next_val    (o_val[g+1]),
         .next_slot   (o_slot[g+1]),
         .own_vld     (o_vld[g]),
         .own_val     (o_val[g]),
         .own_slot    (o_slot[g]),
         .comp_vld    (c_vld[g+1]),
         .comp_val    (c_val[g+1]),
         .comp_slot   (c_slot[g+1]),
         .link_out    (link[g+1])
      );
   end

   always_comb begin
      if (oldest_ff == SLOT_W'(WINDOW - 1)) begin
         oldest_in = '0;
      end else begin
         oldest_in = oldest_ff + 1'b1;
      end
      fill_in = full ? fill_ff : fill_ff + 1'b1;
      if (accept) begin
         pend_in = 1'b1;
      end else begin
         pend_in = pend_ff && !capture;
      end
      if (capture) begin
         rsp_vld_in = 1'b1;
      end else begin
         rsp_vld_in = rsp_vld_ff && rsp_stall;
      end
      pick = SLOT_W'(fill_ff >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff  <= '0;
         fill_ff    <= '0;
         pend_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (accept) begin
            oldest_ff <= oldest_in;
            fill_ff   <= fill_in;
         end
         pend_ff    <= pend_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Read the median cell once the chain has settled on the last beat.
   always_ff @(posedge clock) begin
      if (capture) begin
         median_ff <= swmf_pkg::MEDIAN_W'(o_val[pick]);
      end
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_median_value = median_ff;

endmodule
